### hdl/bc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bc_pkg;

	localparam int unsigned N_W    = 6;
	localparam int unsigned ACC_W  = 64;
	localparam int unsigned COEF_W = 59;

	// largest n whose intermediate products fit in the accumulator
	localparam logic [N_W-1:0] N_LIMIT = 6'd62;

	typedef struct packed {
		logic [N_W-1:0] n;
		logic [N_W-1:0] k;
	} in_t;

	typedef struct packed {
		logic [COEF_W-1:0] coefficient;
		logic              out_of_range;
	} out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

### hdl/bc_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// shift-add multiplier, one bit of the narrow operand per cycle, msb first
module bc_mul (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [bc_pkg::ACC_W-1:0] a,
	input  wire logic [bc_pkg::N_W-1:0]   b,
	output logic                          done,
	output logic [bc_pkg::ACC_W-1:0]      prod
);
	import bc_pkg::*;

	localparam logic [2:0] LAST = 3'(N_W - 1);

	logic [ACC_W-1:0] a_q;
	logic [N_W-1:0]   b_q;
	logic [ACC_W-1:0] p_q;
	logic [2:0]       cnt_q;
	logic             busy_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			p_q <= '0;
		end else if (busy_q) begin
			p_q <= {p_q[ACC_W-2:0], 1'b0} + (b_q[N_W-1] ? a_q : '0);
			b_q <= {b_q[N_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign prod = p_q;

endmodule

`default_nettype wire

### hdl/bc_div.sv
`timescale 1ns / 1ps
`default_nettype none

// restoring divider by a small divisor, one quotient bit per cycle
module bc_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [bc_pkg::ACC_W-1:0] dividend,
	input  wire logic [bc_pkg::N_W-1:0]   divisor,
	output logic                          done,
	output logic [bc_pkg::ACC_W-1:0]      quot
);
	import bc_pkg::*;

	localparam logic [5:0] LAST = 6'(ACC_W - 1);

	logic [ACC_W-1:0] q_q;
	logic [N_W-1:0]   d_q;
	logic [N_W-1:0]   rem_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [N_W:0]     trial;
	logic [N_W-1:0]   diff;
	logic             ge;

	// remainder stays below the divisor, so one extra bit covers the trial
	assign trial = {rem_q, q_q[ACC_W-1]};
	// when the trial is not below the divisor the difference fits in N_W bits
	assign diff  = trial[N_W-1:0] - d_q;
	assign ge    = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			d_q   <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff : trial[N_W-1:0];
			q_q   <= {q_q[ACC_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

`default_nettype wire

### hdl/binomial_coefficient_core.sv
`timescale 1ns / 1ps
`default_nettype none

// binomial coefficient core: exact C(n,k) for n up to 62
// input channel in_valid / in_ready / in_data carries one item {n, k}
// output channel out_valid / out_ready / out_data carries {coefficient, out_of_range}
// one result item per input item, in order
// k is first folded to min(k, n-k); k above n gives 0, a folded k of 0 gives 1,
// a folded k of 1 gives n, and n of 63 gives 0 with out_of_range set
// otherwise the product starts at n and for i = 2..k is multiplied by n-i+1
// on a bit-serial shift-add unit and divided exactly by i on a restoring divider;
// the sequencer starts the multiplier, then the divider, then the next step, and
// after the last step hands the result over to the output register
// trivial cases skip both units and go from accept straight to the handoff
// one item is worked on at a time: in_ready is high only while the sequencer idles
// the result sits in an output register; while the receiver stalls the next item
// is still accepted and computed, and the sequencer then waits to hand it over
// reset clears the sequencer, unit controls and output valid; datapath registers are not reset
module binomial_coefficient_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire bc_pkg::in_t  in_data,
	output logic              out_valid,
	input  wire logic         out_ready,
	output bc_pkg::out_t      out_data
);
	import bc_pkg::*;

	state_t state_q;
	state_t state_d;

	logic [ACC_W-1:0] acc_q;
	logic             oor_q;
	logic [N_W-1:0]   n_q;
	logic [N_W-1:0]   kr_q;
	logic [N_W-1:0]   i_q;
	logic             mul_start_q;
	logic             div_start_q;
	logic             out_valid_q;
	out_t             out_q;

	logic             accept;
	logic             handoff;
	logic [N_W-1:0]   mul_b;
	logic             mul_done;
	logic [ACC_W-1:0] mul_prod;
	logic             div_done;
	logic [ACC_W-1:0] div_quot;

	// input folding
	logic [N_W:0]     k2;
	logic [N_W-1:0]   k_fold;

	assign k2     = {in_data.k, 1'b0};
	assign k_fold = (k2 > {1'b0, in_data.n}) ? (in_data.n - in_data.k) : in_data.k;

	// factor for the current step: n - i + 1
	assign mul_b = n_q - i_q + 6'd1;

	bc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (acc_q),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	bc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (acc_q),
		.divisor  (i_q),
		.done     (div_done),
		.quot     (div_quot)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		accept   = 1'b0;
		handoff  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				accept   = in_valid;
				if (in_valid) begin
					if (in_data.n > N_LIMIT || in_data.k > in_data.n || k_fold < 6'd2) begin
						state_d = ST_FIN;
					end else begin
						state_d = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				if (mul_done) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = (i_q == kr_q) ? ST_FIN : ST_MUL;
				end
			end
			ST_FIN: begin
				// output register free or being emptied this cycle
				handoff = !out_valid_q || out_ready;
				if (handoff) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mul_start_q <= (accept && state_d == ST_MUL)
				|| (state_q == ST_DIV && div_done && i_q != kr_q);
			div_start_q <= state_q == ST_MUL && mul_done;
			if (handoff) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			n_q   <= in_data.n;
			kr_q  <= k_fold;
			i_q   <= 6'd2;
			oor_q <= in_data.n > N_LIMIT;
			if (in_data.n > N_LIMIT) begin
				acc_q <= '0;
			end else if (in_data.k > in_data.n) begin
				acc_q <= '0;
			end else if (k_fold == '0) begin
				acc_q <= ACC_W'(1);
			end else begin
				// folded k of one gives n, and n also seeds the running product
				acc_q <= ACC_W'(in_data.n);
			end
		end else if (state_q == ST_MUL && mul_done) begin
			acc_q <= mul_prod;
		end else if (state_q == ST_DIV && div_done) begin
			acc_q <= div_quot;
			if (i_q != kr_q) begin
				i_q <= i_q + 6'd1;
			end
		end
		if (handoff) begin
			out_q.coefficient  <= acc_q[COEF_W-1:0];
			out_q.out_of_range <= oor_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	// an out of range item always reports a zero coefficient
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.out_of_range |-> out_data.coefficient == '0)
		else $error("out_of_range with nonzero coefficient");

	// multiplier and divider never finish in the same cycle
	a_units_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_done && div_done))
		else $error("multiplier and divider done together");

	// an accepted item blocks the input until it is handed over
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after accept");

	// a unit start only happens while the loop is running
	a_start_in_loop: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start_q || div_start_q |-> state_q == ST_MUL || state_q == ST_DIV)
		else $error("unit start outside the loop");
`endif

endmodule

`default_nettype wire

### dv/tb_binomial_coefficient_core.sv
`timescale 1ns / 1ps

module tb_binomial_coefficient_core;

	import bc_pkg::*;

	// the limit leaves wide margin for the ~290 items, even if all were of the slowest kind
	localparam int unsigned CYCLE_LIMIT = 3_000_000;
	// quiet time after the last result, longer than the slowest item
	localparam int unsigned DRAIN_CYCLES = 2400;
	localparam int unsigned MAX_REPORTS = 10;
	localparam int unsigned RANDOM_ITEMS = 267;

	// receiver stall styles
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_RANDOM,
		RX_BLOCKY
	} rx_mode_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	out_t pending_choices[$];
	int unsigned fail_count;
	int unsigned cycle_count;
	int unsigned burst_left;

	binomial_coefficient_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// exact n choose k on a 64-bit running product, folded k, range flag for n of 63
	function automatic out_t choose_count(input logic [N_W-1:0] n_val, input logic [N_W-1:0] k_val);
		out_t        res;
		logic [63:0] prod;
		int unsigned nn;
		int unsigned kk;
		res = '0;
		nn = 32'(n_val);
		kk = 32'(k_val);
		if (n_val > N_LIMIT) begin
			res.out_of_range = 1'b1;
			return res;
		end
		if (kk > nn)
			return res;
		if (2 * kk > nn)
			kk = nn - kk;
		if (kk == 0) begin
			prod = 64'd1;
		end else begin
			prod = 64'(nn);
			for (int unsigned i = 2; i <= kk; i++) begin
				prod = prod * 64'(nn - i + 1);
				prod = prod / 64'(i);
			end
		end
		res.coefficient = prod[COEF_W-1:0];
		return res;
	endfunction

	// one item on the input channel; valid stays up across a burst
	task automatic send_item(input logic [N_W-1:0] n_val, input logic [N_W-1:0] k_val);
		in_t item;
		item.n = n_val;
		item.k = k_val;
		@(negedge clk);
		in_valid = 1'b1;
		in_data = item;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_choices.push_back(choose_count(n_val, k_val));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			// end of burst: drop valid, scramble the idle payload, wait a while
			@(negedge clk);
			in_valid = 1'b0;
			in_data = 12'($urandom_range(0, 4095));
			repeat ($urandom_range(0, 10))
				@(negedge clk);
			burst_left = $urandom_range(0, 24);
		end
	endtask

	// stop offering items and let every expected result come back
	task automatic wait_drained();
		if (in_valid) begin
			@(negedge clk);
			in_valid = 1'b0;
			in_data = 12'($urandom_range(0, 4095));
		end
		while (pending_choices.size() != 0)
			@(posedge clk);
	endtask

	// k above n, n of 63, folded k of 0 and 1
	task automatic test_trivial_cases();
		send_item(6'd0, 6'd0);
		send_item(6'd0, 6'd63);
		send_item(6'd5, 6'd9);
		send_item(6'd62, 6'd63);
		send_item(6'd63, 6'd0);
		send_item(6'd63, 6'd63);
		send_item(6'd63, 6'd31);
		send_item(6'd10, 6'd0);
		send_item(6'd10, 6'd10);
		send_item(6'd1, 6'd1);
		send_item(6'd7, 6'd1);
		send_item(6'd7, 6'd6);
		send_item(6'd62, 6'd0);
		wait_drained();
	endtask

	// largest coefficients and longest products, plus a few short and trivial ones
	task automatic test_extremes();
		send_item(6'd62, 6'd31);
		send_item(6'd62, 6'd30);
		send_item(6'd62, 6'd32);
		send_item(6'd61, 6'd30);
		send_item(6'd61, 6'd31);
		send_item(6'd60, 6'd30);
		send_item(6'd62, 6'd61);
		send_item(6'd62, 6'd2);
		send_item(6'd2, 6'd1);
		send_item(6'd31, 6'd15);
		wait_drained();
	endtask

	// mostly short products, some full-range pairs, some trivial ones, a few deep ones
	task automatic test_random_pairs();
		int unsigned sel;
		int unsigned n_val;
		int unsigned k_val;
		int unsigned dist_k;
		for (int unsigned idx = 0; idx < RANDOM_ITEMS; idx++) begin
			sel = $urandom_range(0, 99);
			if (sel < 15) begin
				n_val = $urandom_range(0, 63);
				k_val = $urandom_range(0, 63);
			end else if (sel < 22) begin
				n_val = 63;
				k_val = $urandom_range(0, 63);
			end else if (sel < 30) begin
				n_val = $urandom_range(0, 62);
				k_val = $urandom_range(n_val + 1, 63);
			end else if (sel < 33) begin
				// near the middle of a tall row
				n_val = $urandom_range(56, 62);
				k_val = n_val / 2 + $urandom_range(0, 2) - 1;
			end else begin
				// folded k kept small so most items finish quickly
				n_val = $urandom_range(0, 62);
				dist_k = $urandom_range(0, (n_val < 6) ? n_val : 6);
				k_val = $urandom_range(0, 1) ? dist_k : n_val - dist_k;
			end
			send_item(n_val[N_W-1:0], k_val[N_W-1:0]);
		end
		wait_drained();
	endtask

	// receiver: open stretches, random stalls, and long blocks of back-pressure
	initial begin
		rx_mode_t    mode;
		int unsigned span;
		int unsigned hold;
		out_ready = 1'b0;
		hold = 0;
		@(posedge arst_n);
		forever begin
			mode = rx_mode_t'($urandom_range(0, 2));
			span = $urandom_range(20, 300);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					RX_OPEN: begin
						out_ready = 1'b1;
					end
					RX_RANDOM: begin
						out_ready = 1'($urandom_range(0, 1));
					end
					default: begin
						if (hold > 0) begin
							hold--;
							out_ready = 1'b0;
						end else begin
							out_ready = 1'b1;
							if ($urandom_range(0, 7) == 0)
								hold = $urandom_range(5, 40);
						end
					end
				endcase
			end
		end
	end

	// result checker: every accepted result against the oldest expectation
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_choices.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected result: coefficient %0d out_of_range %0b",
						out_data.coefficient, out_data.out_of_range);
			end else begin
				want = pending_choices.pop_front();
				if (out_data.coefficient !== want.coefficient ||
						out_data.out_of_range !== want.out_of_range) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("mismatch: coefficient exp %0d got %0d, out_of_range exp %0b got %0b",
							want.coefficient, out_data.coefficient,
							want.out_of_range, out_data.out_of_range);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL binomial_coefficient_core");
			$finish;
		end
	end

	initial begin
		fail_count = 0;
		cycle_count = 0;
		burst_left = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_trivial_cases();
		test_extremes();
		test_random_pairs();

		// any late or spurious result would show up here
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (fail_count == 0 && pending_choices.size() == 0) begin
			$display("PASS binomial_coefficient_core");
		end else begin
			$display("FAIL binomial_coefficient_core");
		end
		$finish;
	end

endmodule
